>>> hdl/http_request_header_parser_unit_defines.svh
// assertion macros for the http request header parser
`ifndef HTTP_REQUEST_HEADER_PARSER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define HRP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("hrp assertion failed");
// next-cycle implication, checked out of reset
`define HRP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("hrp assertion failed");
`else
`define HRP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define HRP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

>>> hdl/hrp_pkg.sv
// shared types and constants of the http request header parser
package hrp_pkg;

  // parameter defaults and reset values
  localparam int PATH_SLOTS_DEF = 32;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd60;

  // size of the path head kept for classification
  localparam int HEAD_LEN = 5;
  localparam int HEAD_IDX_W = 3;

  // event kinds on the input channel
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_CLOSE = 2'd3;

  // result event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PATH_BYTE = 3'd1;
  localparam logic [2:0] EV_READY     = 3'd2;
  localparam logic [2:0] EV_WS_UPG    = 3'd3;
  localparam logic [2:0] EV_WS_BYTE   = 3'd4;
  localparam logic [2:0] EV_TIMEOUT   = 3'd5;

  // request kinds
  localparam logic [1:0] KIND_STATIC  = 2'd0;
  localparam logic [1:0] KIND_DYNAMIC = 2'd1;
  localparam logic [1:0] KIND_INDEX   = 2'd2;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_S     = 8'h73;

  // one input request
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } item_t;

  // one result
  typedef struct packed {
    logic [2:0] event_res;
    logic [1:0] request_kind;
    logic [7:0] out_byte;
    logic [4:0] path_pos;
    logic [4:0] path_length;
  } result_t;

endpackage

>>> hdl/hrp_input_stage.sv
// input register of the http request header parser
module hrp_input_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_cmd,
  input  logic [7:0]     in_rx_byte,
  input  logic           adv,
  output logic           item_vld,
  output hrp_pkg::item_t item
);

  logic           vld_r;
  logic           vld_nxt;
  hrp_pkg::item_t item_r;
  logic           accept;

  // hold off new requests only when the held one cannot move on
  assign in_stall = vld_r & ~adv;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd     <= in_cmd;
      item_r.rx_byte <= in_rx_byte;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> hdl/hrp_core.sv
// parser state and per-request update logic
module hrp_core #(
  parameter int PATH_SLOTS = hrp_pkg::PATH_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             fire,
  input  hrp_pkg::item_t   item,
  output hrp_pkg::result_t res
);

  localparam int IDX_W = $clog2(PATH_SLOTS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(PATH_SLOTS - 1);

  // parser phases
  localparam logic [2:0] PH_NONE   = 3'd0;
  localparam logic [2:0] PH_METHOD = 3'd1;
  localparam logic [2:0] PH_PATH   = 3'd2;
  localparam logic [2:0] PH_PROTO  = 3'd3;
  localparam logic [2:0] PH_FLAG   = 3'd4;
  localparam logic [2:0] PH_INFLAG = 3'd5;
  localparam logic [2:0] PH_READY  = 3'd6;
  localparam logic [2:0] PH_WS     = 3'd7;

  logic [2:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [15:0]      limit_r;
  logic [hrp_pkg::HEAD_LEN-1:0][7:0] head_r;

  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] next_slot;
  logic [IDX_W-1:0] len;
  logic [IDX_W+4:0] slot_ext;
  logic [IDX_W+4:0] len_ext;
  logic [IDX_W+4:0] idx_ext;
  logic             head_we;
  logic             is_ws;
  logic             lead_slash;
  logic             is_dyn;
  logic             is_index;
  logic [1:0]       kind_cls;
  logic [7:0]       c;

  assign c = item.rx_byte;

  // path slot arithmetic, the last slot absorbs overflow
  assign slot      = idx_r;
  assign next_slot = (slot == LAST) ? LAST : slot + 1'b1;
  assign len       = next_slot - 1'b1;
  assign head_we   = (slot < IDX_W'(hrp_pkg::HEAD_LEN));
  assign slot_ext  = {5'b0, slot};
  assign len_ext   = {5'b0, len};
  assign idx_ext   = {5'b0, idx_r};

  // websocket tag match on the kept head
  assign is_ws = (len >= IDX_W'(hrp_pkg::HEAD_LEN)) &&
                 (head_r[0] == hrp_pkg::CH_SLASH) && (head_r[1] == hrp_pkg::CH_D) &&
                 (head_r[2] == hrp_pkg::CH_SLASH) && (head_r[3] == hrp_pkg::CH_W) &&
                 (head_r[4] == hrp_pkg::CH_S);

  // classification: optional leading slash, then d/ or nothing
  assign lead_slash = (len != '0) && (head_r[0] == hrp_pkg::CH_SLASH);
  assign is_dyn = lead_slash ?
                  ((len >= IDX_W'(3)) && (head_r[1] == hrp_pkg::CH_D) &&
                   (head_r[2] == hrp_pkg::CH_SLASH)) :
                  ((len >= IDX_W'(2)) && (head_r[0] == hrp_pkg::CH_D) &&
                   (head_r[1] == hrp_pkg::CH_SLASH));
  assign is_index = (len == '0) || (lead_slash && (len == IDX_W'(1)));

  always_comb begin
    if (is_dyn) begin
      kind_cls = hrp_pkg::KIND_DYNAMIC;
    end else if (is_index) begin
      kind_cls = hrp_pkg::KIND_INDEX;
    end else begin
      kind_cls = hrp_pkg::KIND_STATIC;
    end
  end

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    idle_nxt  = idle_r;
    kind_nxt  = kind_r;
    res       = '0;
    unique case (item.cmd)
      hrp_pkg::CMD_OPEN: begin
        phase_nxt = PH_METHOD;
        idx_nxt   = '0;
        idle_nxt  = '0;
      end
      hrp_pkg::CMD_CLOSE: begin
        phase_nxt = PH_NONE;
      end
      hrp_pkg::CMD_TICK: begin
        if ((phase_r >= PH_METHOD) && (phase_r <= PH_INFLAG)) begin
          if (idle_r > limit_r) begin
            phase_nxt     = PH_NONE;
            res.event_res = hrp_pkg::EV_TIMEOUT;
          end
          if (idle_r != '1) begin
            idle_nxt = idle_r + 16'd1;
          end
        end
      end
      default: begin
        idle_nxt = '0;
        unique case (phase_r)
          PH_METHOD: begin
            if (c == hrp_pkg::CH_SPACE) begin
              phase_nxt = PH_PATH;
              idx_nxt   = '0;
            end
          end
          PH_PATH: begin
            if (c == hrp_pkg::CH_SPACE) begin
              idx_nxt         = len;
              res.path_length = len_ext[4:0];
              if (is_ws) begin
                phase_nxt     = PH_WS;
                res.event_res = hrp_pkg::EV_WS_UPG;
              end else begin
                phase_nxt = PH_PROTO;
                kind_nxt  = kind_cls;
              end
            end else begin
              idx_nxt       = next_slot;
              res.event_res = hrp_pkg::EV_PATH_BYTE;
              res.out_byte  = c;
              res.path_pos  = slot_ext[4:0];
            end
          end
          PH_PROTO, PH_INFLAG: begin
            if (c == hrp_pkg::CH_LF) begin
              phase_nxt = PH_FLAG;
            end
          end
          PH_FLAG: begin
            if (c == hrp_pkg::CH_LF) begin
              phase_nxt        = PH_READY;
              res.event_res    = hrp_pkg::EV_READY;
              res.request_kind = kind_r;
              res.path_length  = idx_ext[4:0];
            end else if (c != hrp_pkg::CH_CR) begin
              phase_nxt = PH_INFLAG;
            end
          end
          PH_WS: begin
            res.event_res = hrp_pkg::EV_WS_BYTE;
            res.out_byte  = c;
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      idx_r   <= '0;
      idle_r  <= '0;
      kind_r  <= hrp_pkg::KIND_STATIC;
      limit_r <= hrp_pkg::IDLE_LIMIT_RST;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        idle_r  <= idle_nxt;
        kind_r  <= kind_nxt;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // path head store, only entries below the kept length are ever read
  always_ff @(posedge clk) begin
    if (fire && (item.cmd == hrp_pkg::CMD_BYTE) && (phase_r == PH_PATH) && head_we) begin
      head_r[slot[hrp_pkg::HEAD_IDX_W-1:0]] <= c;
    end
  end

endmodule

>>> hdl/hrp_output_stage.sv
// result register of the http request header parser
module hrp_output_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hrp_pkg::result_t res,
  output logic             adv,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_event_res,
  output logic [1:0]       out_request_kind,
  output logic [7:0]       out_out_byte,
  output logic [4:0]       out_path_pos,
  output logic [4:0]       out_path_length
);

  logic             vld_r;
  hrp_pkg::result_t res_r;

  // register free or being emptied this cycle
  assign adv = ~vld_r | ~out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid        = vld_r;
  assign out_event_res    = res_r.event_res;
  assign out_request_kind = res_r.request_kind;
  assign out_out_byte     = res_r.out_byte;
  assign out_path_pos     = res_r.path_pos;
  assign out_path_length  = res_r.path_length;

endmodule

>>> hdl/http_request_header_parser_unit.sv
// Per-connection HTTP request parser: one event per request (byte, open, tick,
// disconnect), one result per request. Each request passes the input register
// and then the result register, with the parser state updated in the single
// logic stage between them; a new request is taken every cycle unless in_stall
// holds it off. in_stall rises only while the input register is full and the
// result register is held by out_stall. idle_limit must be written through
// cfg_wr_en/cfg_wr_data while no request is in flight; the block does not enforce it.
`include "http_request_header_parser_unit_defines.svh"

module http_request_header_parser_unit #(
  parameter int PATH_SLOTS = hrp_pkg::PATH_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [1:0]  out_request_kind,
  output logic [7:0]  out_out_byte,
  output logic [4:0]  out_path_pos,
  output logic [4:0]  out_path_length
);

  logic             adv;
  logic             item_vld;
  logic             fire;
  hrp_pkg::item_t   item;
  hrp_pkg::result_t res;

  // input register
  hrp_input_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .adv        (adv),
    .item_vld   (item_vld),
    .item       (item)
  );

  assign fire = item_vld & adv;

  // parser state and update
  hrp_core #(
    .PATH_SLOTS (PATH_SLOTS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .res         (res)
  );

  // result register
  hrp_output_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (fire),
    .res              (res),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_request_kind (out_request_kind),
    .out_out_byte     (out_out_byte),
    .out_path_pos     (out_path_pos),
    .out_path_length  (out_path_length)
  );

  // stall only with a held request in the input register
  `HRP_ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, item_vld)
  // every processed request shows up as a result next cycle
  `HRP_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_valid)
  // the space that ends the path is never reported as a path byte
  `HRP_ASSERT_IMPL(a_no_space_in_path, clk, rst_n,
    out_valid && (out_event_res == hrp_pkg::EV_PATH_BYTE),
    out_out_byte != hrp_pkg::CH_SPACE)

endmodule

>>> tb/tb.sv
// self-checking testbench for the http request header parser unit
module tb;
  import hrp_pkg::*;

  localparam int PATH_SLOTS  = PATH_SLOTS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 4;

  // connection phases of the parser
  typedef enum logic [2:0] {
    PH_IDLE, PH_METHOD, PH_PATH, PH_PROTO, PH_LINE_START, PH_HEADER, PH_READY, PH_WS
  } parse_phase_e;

  // mirror of the parser state plus the results still owed by the block
  class request_line_tracker;
    logic [15:0]  idle_limit;
    parse_phase_e phase;
    int unsigned  path_index;
    logic [7:0]   path_head [HEAD_LEN];
    int unsigned  idle_count;
    logic [1:0]   kind_reg;
    result_t      owed_results[$];
    int           mismatches;

    function new();
      idle_limit = IDLE_LIMIT_RST;
      phase      = PH_IDLE;
      path_index = 0;
      foreach (path_head[i]) path_head[i] = 8'h00;
      idle_count = 0;
      kind_reg   = KIND_STATIC;
      mismatches = 0;
    endfunction

    function void set_idle_limit(logic [15:0] value);
      idle_limit = value;
    endfunction

    function int results_owed();
      return owed_results.size();
    endfunction

    // head character of the kept path, zero at and past its end
    function logic [7:0] head_at(int unsigned i, int unsigned len);
      if (i >= len || i >= HEAD_LEN) return 8'h00;
      return path_head[i];
    endfunction

    // advance the mirror by one accepted request and queue its result
    function void take_request(item_t req);
      result_t     res;
      int unsigned slot, next_slot, len, off;
      logic        is_ws;
      res = '0;
      case (req.cmd)
        CMD_OPEN: begin
          phase      = PH_METHOD;
          path_index = 0;
          idle_count = 0;
        end
        CMD_CLOSE: phase = PH_IDLE;
        CMD_TICK: begin
          if (phase >= PH_METHOD && phase <= PH_HEADER) begin
            if (idle_count > idle_limit) begin
              phase         = PH_IDLE;
              res.event_res = EV_TIMEOUT;
            end
            if (idle_count < 65535) idle_count++;
          end
        end
        CMD_BYTE: begin
          idle_count = 0;
          case (phase)
            PH_METHOD: begin
              if (req.rx_byte == CH_SPACE) begin
                phase      = PH_PATH;
                path_index = 0;
              end
            end
            PH_PATH: begin
              // last slot is rewritten once the store is full
              slot = (path_index >= PATH_SLOTS) ? PATH_SLOTS - 1 : path_index;
              if (slot < HEAD_LEN) path_head[slot] = req.rx_byte;
              next_slot = (slot + 1 == PATH_SLOTS) ? slot : slot + 1;
              if (req.rx_byte == CH_SPACE) begin
                len             = next_slot - 1;
                path_index      = len;
                res.path_length = len[4:0];
                is_ws = len >= HEAD_LEN && path_head[0] == CH_SLASH && path_head[1] == CH_D &&
                        path_head[2] == CH_SLASH && path_head[3] == CH_W && path_head[4] == CH_S;
                if (is_ws) begin
                  phase         = PH_WS;
                  res.event_res = EV_WS_UPG;
                end else begin
                  // classify after an optional leading slash
                  phase = PH_PROTO;
                  off   = (head_at(0, len) == CH_SLASH) ? 1 : 0;
                  if (head_at(off, len) == CH_D && head_at(off + 1, len) == CH_SLASH)
                    kind_reg = KIND_DYNAMIC;
                  else if (off >= len)
                    kind_reg = KIND_INDEX;
                  else
                    kind_reg = KIND_STATIC;
                end
              end else begin
                path_index    = next_slot;
                res.event_res = EV_PATH_BYTE;
                res.out_byte  = req.rx_byte;
                res.path_pos  = slot[4:0];
              end
            end
            PH_PROTO: begin
              if (req.rx_byte == CH_LF) phase = PH_LINE_START;
            end
            PH_LINE_START: begin
              if (req.rx_byte == CH_LF) begin
                phase            = PH_READY;
                res.event_res    = EV_READY;
                res.request_kind = kind_reg;
                res.path_length  = path_index[4:0];
              end else if (req.rx_byte != CH_CR) begin
                phase = PH_HEADER;
              end
            end
            PH_HEADER: begin
              if (req.rx_byte == CH_LF) phase = PH_LINE_START;
            end
            PH_WS: begin
              res.event_res = EV_WS_BYTE;
              res.out_byte  = req.rx_byte;
            end
            default: ;
          endcase
        end
      endcase
      owed_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // match one result against the oldest owed one
    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result: event_res %0d", got.event_res);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("request_kind", want.request_kind, got.request_kind);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("path_pos", want.path_pos, got.path_pos);
      compare_field("path_length", want.path_length, got.path_length);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [1:0]  out_request_kind;
  logic [7:0]  out_out_byte;
  logic [4:0]  out_path_pos;
  logic [4:0]  out_path_length;

  request_line_tracker tracker;
  item_t session_q[$];
  int    sender_pct   = 0;
  int    receiver_pct = 0;
  int    tick_pct     = 0;
  int    hold_left    = 0;
  int    quiet_cycles = 0;

  http_request_header_parser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_request_kind (out_request_kind),
    .out_out_byte     (out_out_byte),
    .out_path_pos     (out_path_pos),
    .out_path_length  (out_path_length)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall or a long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_pct);
    end
  end

  // check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result({out_event_res, out_request_kind, out_out_byte,
                            out_path_pos, out_path_length});
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void push_cmd(logic [1:0] cmd);
    session_q.push_back(item_t'{cmd, 8'($urandom)});
  endfunction

  // a received byte, sometimes preceded by a burst of ticks
  function automatic void push_byte(logic [7:0] b);
    if ($urandom_range(0, 99) < tick_pct)
      repeat ($urandom_range(1, 6)) push_cmd(CMD_TICK);
    session_q.push_back(item_t'{CMD_BYTE, b});
  endfunction

  function automatic logic [7:0] rand_char(logic [7:0] excl_a, logic [7:0] excl_b);
    logic [7:0] c;
    do
      c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126)) : 8'($urandom);
    while (c == excl_a || c == excl_b);
    return c;
  endfunction

  function automatic void push_line_end();
    if ($urandom_range(0, 1)) push_byte(CH_CR);
    push_byte(CH_LF);
  endfunction

  // one well-formed request with random content
  function automatic void build_request();
    int         shape;
    logic [7:0] path[$];
    push_cmd(CMD_OPEN);
    repeat ($urandom_range(0, 6)) push_byte(rand_char(CH_SPACE, CH_SPACE));
    push_byte(CH_SPACE);
    shape = $urandom_range(0, 9);
    case (shape)
      0: ;
      2, 3: path = '{CH_SLASH, CH_D, CH_SLASH, CH_W, CH_S};
      4: path = '{CH_SLASH, CH_D, CH_SLASH};
      5: path = '{CH_D, CH_SLASH};
      6: path = '{CH_SLASH, CH_D, CH_SLASH, CH_W};
      default: path = '{CH_SLASH};
    endcase
    // shape 7 can overflow the path store
    repeat ((shape == 7) ? $urandom_range(27, 40) : $urandom_range(0, 6))
      path.push_back(rand_char(CH_SPACE, CH_SPACE));
    foreach (path[i]) push_byte(path[i]);
    push_byte(CH_SPACE);
    if (shape == 2 || shape == 3) begin
      // websocket pass-through, spaces included
      repeat ($urandom_range(0, 8)) push_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 8)) push_byte(rand_char(CH_LF, CH_LF));
      push_line_end();
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(1, 10)) push_byte(rand_char(CH_LF, CH_CR));
        push_line_end();
      end
      push_line_end();
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
    end
    if ($urandom_range(0, 1)) push_cmd(CMD_CLOSE);
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_request(input item_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= req.cmd;
    in_rx_byte <= req.rx_byte;
    do @(posedge clk); while (in_stall);
    tracker.take_request(req);
  endtask

  task automatic send_queue();
    foreach (session_q[i]) send_request(session_q[i]);
    session_q.delete();
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.results_owed() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_idle_limit(input logic [15:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    tracker.set_idle_limit(value);
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  // random traffic: mostly whole requests, some cut short, some noise
  task automatic run_phase(input logic [15:0] limit, input int snd_pct, input int rcv_pct,
                           input bit with_hold, input int target);
    int sent;
    int pick;
    write_idle_limit(limit);
    sender_pct   = snd_pct;
    receiver_pct = rcv_pct;
    if (with_hold) begin
      @(posedge clk);
      hold_left = HOLD_CYCLES;
    end
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 6)) session_q.push_back(item_t'{2'($urandom), 8'($urandom)});
      end else begin
        build_request();
        if (pick < 22) session_q = session_q[0:$urandom_range(0, session_q.size() - 1)];
      end
      sent += session_q.size();
      send_queue();
    end
  endtask

  initial begin
    tracker     = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_cmd      = CMD_BYTE;
    in_rx_byte  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: idle events, empty path, websocket, reopen, timeout
    write_idle_limit(16'd0);
    sender_pct   = 27;
    receiver_pct = 45;
    push_byte(8'hff);
    push_cmd(CMD_TICK);
    push_cmd(CMD_OPEN);
    push_byte(CH_SPACE);
    push_byte(CH_SPACE);
    push_byte(8'h78);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(8'h00);
    push_cmd(CMD_OPEN);
    push_byte(CH_SPACE);
    push_byte(CH_SLASH);
    push_byte(CH_D);
    push_byte(CH_SLASH);
    push_byte(CH_W);
    push_byte(CH_S);
    push_byte(CH_SPACE);
    push_byte(8'h80);
    push_cmd(CMD_TICK);
    push_cmd(CMD_OPEN);
    push_cmd(CMD_TICK);
    push_cmd(CMD_TICK);
    push_cmd(CMD_CLOSE);
    send_queue();

    tick_pct = 6;
    run_phase(16'hffff, 27, 45, 1'b0, 200);
    run_phase(16'd3, 45, 27, 1'b0, 200);
    run_phase(16'($urandom_range(0, 6)), 0, 0, 1'b1, 200);
    run_phase(IDLE_LIMIT_RST, 0, 0, 1'b0, 200);
    drain();

    if (tracker.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
